>>> src/tlb_pkg.sv
// Shared types for the TLB / page-table translation block.
`default_nettype none
package tlb_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_PRIME = 2'd1,
    REQ_XLATE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XLATE,
    ST_PRIME
  } state_t;

  typedef enum logic [1:0] {
    RD_REQ_PAGE,
    RD_ZERO,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    latch_req;
    logic    pt_write;
    logic    pt_rd_en;
    rd_sel_t rd_sel;
    logic    prime_start;
    logic    prime_step;
    logic    xlate_commit;
  } cmd_t;

  typedef struct packed {
    logic prime_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> src/tlb_req_if.sv
// Request channel: valid/ready plus request word.
`default_nettype none
interface tlb_req_if #(
  parameter int OFFSET_WIDTH = 3,
  parameter int PAGE_WIDTH   = 5,
  parameter int FRAME_WIDTH  = 13
);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [PAGE_WIDTH-1:0]            entry_page;
  logic [FRAME_WIDTH-1:0]           entry_frame;
  logic [PAGE_WIDTH+OFFSET_WIDTH-1:0] logical_address;

  modport source (output valid, req_type, entry_page, entry_frame, logical_address,
                  input ready);
  modport sink   (input valid, req_type, entry_page, entry_frame, logical_address,
                  output ready);
endinterface
`default_nettype wire

>>> src/tlb_rsp_if.sv
// Result channel: valid/ready plus translated address word.
`default_nettype none
interface tlb_rsp_if #(
  parameter int OFFSET_WIDTH = 3,
  parameter int FRAME_WIDTH  = 13
);
  logic                                valid;
  logic                                ready;
  logic [FRAME_WIDTH+OFFSET_WIDTH-1:0] physical_address;
  logic                                tlb_hit;

  modport source (output valid, physical_address, tlb_hit, input ready);
  modport sink   (input valid, physical_address, tlb_hit, output ready);
endinterface
`default_nettype wire

>>> src/tlb_ctrl.sv
// Controller FSM: sequences page-table writes, TLB prime sweep and lookups.
`default_nettype none
module tlb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_req_type,
  output logic               in_ready,
  input  wire tlb_pkg::sts_t sts,
  output tlb_pkg::cmd_t      cmd
);
  import tlb_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_XLATE: state_nxt = ST_XLATE;
            REQ_PRIME: state_nxt = ST_PRIME;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_XLATE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_PRIME: begin
        if (sts.prime_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_REQ_PAGE;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_WRITE: cmd.pt_write = 1'b1;
            REQ_PRIME: begin
              cmd.pt_rd_en    = 1'b1;
              cmd.rd_sel      = RD_ZERO;
              cmd.prime_start = 1'b1;
            end
            REQ_XLATE: begin
              cmd.pt_rd_en  = 1'b1;
              cmd.latch_req = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_XLATE: begin
        cmd.xlate_commit = sts.out_free;
      end
      ST_PRIME: begin
        // write slot k from the table word read last cycle, fetch k+1
        cmd.prime_step = 1'b1;
        cmd.pt_rd_en   = 1'b1;
        cmd.rd_sel     = RD_NEXT;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/tlb_dp.sv
// Datapath: page-table memory, TLB entries, FIFO pointer and result register.
`default_nettype none
module tlb_dp #(
  parameter int OFFSET_WIDTH = 3,
  parameter int PAGE_WIDTH   = 5,
  parameter int FRAME_WIDTH  = 13,
  parameter int TLB_ENTRIES  = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [PAGE_WIDTH-1:0]               in_entry_page,
  input  wire logic [FRAME_WIDTH-1:0]              in_entry_frame,
  input  wire logic [PAGE_WIDTH+OFFSET_WIDTH-1:0]  in_logical_address,
  input  wire tlb_pkg::cmd_t                       cmd,
  output tlb_pkg::sts_t                            sts,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [FRAME_WIDTH+OFFSET_WIDTH-1:0]      out_physical_address,
  output logic                                     out_tlb_hit
);
  import tlb_pkg::*;

  localparam int PT_DEPTH = 1 << PAGE_WIDTH;
  localparam int IDX_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int LA_W     = PAGE_WIDTH + OFFSET_WIDTH;

  // page table: undefined until written, no clear
  logic [FRAME_WIDTH-1:0] pt_mem [PT_DEPTH];
  logic [FRAME_WIDTH-1:0] pt_rdata_r;
  logic [PAGE_WIDTH-1:0]  pt_raddr;

  logic [PAGE_WIDTH-1:0]  tlb_pages_r  [TLB_ENTRIES];
  logic [FRAME_WIDTH-1:0] tlb_frames_r [TLB_ENTRIES];

  logic [IDX_W-1:0] replace_r, replace_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [LA_W-1:0]  la_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [LA_W+FRAME_WIDTH-PAGE_WIDTH-1:0] out_pa_r;
  logic                    out_hit_r;

  logic [PAGE_WIDTH-1:0]   la_page;
  logic [OFFSET_WIDTH-1:0] la_off;
  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic [FRAME_WIDTH-1:0]  frame_sel;
  logic                    cnt_last;

  assign la_page  = la_r[LA_W-1:OFFSET_WIDTH];
  assign la_off   = la_r[OFFSET_WIDTH-1:0];
  assign cnt_last = (cnt_r == IDX_W'(TLB_ENTRIES - 1));

  always_comb begin
    case (cmd.rd_sel)
      RD_REQ_PAGE: pt_raddr = in_logical_address[LA_W-1:OFFSET_WIDTH];
      RD_ZERO:     pt_raddr = '0;
      RD_NEXT:     pt_raddr = PAGE_WIDTH'(cnt_r + IDX_W'(1));
      default:     pt_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_write) pt_mem[in_entry_page] <= in_entry_frame;
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_rd_en) pt_rdata_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) la_r <= in_logical_address;
  end

  // lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if (tlb_pages_r[k] == la_page) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign frame_sel = hit ? tlb_frames_r[hit_idx] : pt_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TLB_ENTRIES; k++) begin
        tlb_pages_r[k]  <= '0;
        tlb_frames_r[k] <= '0;
      end
    end else if (cmd.prime_step) begin
      tlb_pages_r[cnt_r]  <= PAGE_WIDTH'(cnt_r);
      tlb_frames_r[cnt_r] <= pt_rdata_r;
    end else if (cmd.xlate_commit && !hit) begin
      tlb_pages_r[replace_r]  <= la_page;
      tlb_frames_r[replace_r] <= pt_rdata_r;
    end
  end

  always_comb begin
    replace_nxt = replace_r;
    if (cmd.prime_start) begin
      replace_nxt = '0;
    end else if (cmd.xlate_commit && !hit) begin
      replace_nxt = (replace_r == IDX_W'(TLB_ENTRIES - 1)) ? '0 : replace_r + IDX_W'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.prime_start) begin
      cnt_nxt = '0;
    end else if (cmd.prime_step) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_r <= '0;
      cnt_r     <= '0;
    end else begin
      replace_r <= replace_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // result register parts the two sides of the handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.xlate_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xlate_commit) begin
      out_pa_r  <= {frame_sel, la_off};
      out_hit_r <= hit;
    end
  end

  assign sts.prime_last = cnt_last;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_hit          = out_hit_r;

endmodule
`default_nettype wire

>>> src/tlb_fifo_page_translate.sv
// Top level: address translation with a FIFO-replaced TLB over a page table.
// Each request word is one of: page-table write (stays idle, no result),
// TLB prime (loads slot k with page k and its table frame, resets the FIFO
// pointer, returns no result; busy until every slot is loaded), or translate
// (a synchronous page-table read, then the TLB search and result; one result
// word with physical_address = {frame, offset} and tlb_hit). The page table is
// a memory with separate read and write addresses that powers up undefined;
// translating or priming through an entry never written returns an arbitrary
// frame. The result sits in an output register, so a new request is taken while
// the previous result waits; a translate holds in its search step only while
// that register is full and not being drained.
`default_nettype none
module tlb_fifo_page_translate #(
  parameter int OFFSET_WIDTH = 3,
  parameter int PAGE_WIDTH   = 5,
  parameter int FRAME_WIDTH  = 13,
  parameter int TLB_ENTRIES  = 4
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tlb_req_if.sink   in_req,
  tlb_rsp_if.source out_rsp
);
  import tlb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .in_ready    (in_req.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  tlb_dp #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .PAGE_WIDTH   (PAGE_WIDTH),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .TLB_ENTRIES  (TLB_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_entry_page        (in_req.entry_page),
    .in_entry_frame       (in_req.entry_frame),
    .in_logical_address   (in_req.logical_address),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_ready            (out_rsp.ready),
    .out_valid            (out_rsp.valid),
    .out_physical_address (out_rsp.physical_address),
    .out_tlb_hit          (out_rsp.tlb_hit)
  );

endmodule
`default_nettype wire
